// ===== design/dgsp_pkg.sv =====
// shared types and constants for the dense graph shortest path block
// no dependencies
package dgsp_pkg;
  localparam int NV = 16;
  localparam int VB = 4;
  localparam int WB = 16;
  localparam int DB = 20;
  localparam logic [DB-1:0] DistInf = '1;
  localparam logic [WB-1:0] WeightInf = '1;

  typedef enum logic [0:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_SEL_RD,
    ST_SEL,
    ST_MARK,
    ST_RELAX_RD,
    ST_RELAX_WR,
    ST_WALK_RD,
    ST_WALK_DST,
    ST_WALK_OUT
  } state_e;

  // one output item
  typedef struct packed {
    logic [VB-1:0] vertex;
    logic [WB-1:0] edge_cost;
    logic [DB-1:0] total_distance;
    logic          reachable;
    logic          last;
  } res_t;
endpackage

// ===== design/dgsp_wmem.sv =====
// weight matrix memory, one write and one registered read port
// depends on dgsp_pkg
module dgsp_wmem import dgsp_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [2*VB-1:0] waddr_i,
  input  logic [WB-1:0]   wdata_i,
  input  logic [2*VB-1:0] raddr_i,
  output logic [WB-1:0]   rdata_o
);
  logic [WB-1:0] mem [NV*NV];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== design/dgsp_vmem.sv =====
// per-vertex state memory: distance, predecessor, entry cost, visited
// depends on dgsp_pkg
module dgsp_vmem import dgsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [VB-1:0]           waddr_i,
  input  logic [DB+VB+WB:0]       wdata_i,
  input  logic [VB-1:0]           raddr_i,
  output logic [DB+VB+WB:0]       rdata_o
);
  logic [DB+VB+WB:0] mem [NV];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== design/dense_graph_shortest_path.sv =====
// dense graph shortest path: a weight load is written when it is accepted
// a query item stalls the input until its last result item is registered, and while a
// result is held by the receiver: init reads and writes each active vertex entry,
// each selection scans one entry a cycle and then marks; relax reads and writes each vertex
// equal or out-of-range endpoints give their item right after acceptance
// reset (async, active low) clears control and sets vertex_count to 16
module dense_graph_shortest_path import dgsp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          func_i,
  input  logic [3:0]    row_i,
  input  logic [3:0]    col_i,
  input  logic [15:0]   weight_i,
  input  logic [3:0]    origin_i,
  input  logic [3:0]    destination_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [3:0]    vertex_o,
  output logic [15:0]   edge_cost_o,
  output logic [19:0]   total_distance_o,
  output logic          reachable_o,
  output logic          last_o
);
  localparam int EW = DB + VB + WB + 1;

  logic [4:0] vcnt_q;
  logic [VB:0] n_c;
  state_e state_q, state_d;

  // query registers
  logic [VB-1:0] org_q, org_d, dst_q, dst_d;
  logic [VB-1:0] idx_q, idx_d;     // scan index
  logic [VB-1:0] sel_q, sel_d;     // selected vertex
  logic [DB-1:0] seld_q, seld_d;   // distance of selected vertex
  logic [DB-1:0] best_q, best_d;   // running minimum in selection
  logic          found_q, found_d;
  logic [VB:0]   step_q, step_d;   // path items emitted so far
  logic [DB-1:0] tot_q, tot_d;
  logic [VB-1:0] cur_q, cur_d;

  // result register
  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;

  // memory ports
  logic wm_we;
  logic [2*VB-1:0] wm_waddr, wm_raddr;
  logic [WB-1:0] wm_rdata;
  logic vm_we;
  logic [VB-1:0] vm_waddr, vm_raddr;
  logic [EW-1:0] vm_wdata, vm_rdata;

  // vertex entry fields
  logic          e_vis;
  logic [DB-1:0] e_dist;
  logic [VB-1:0] e_pred;
  logic [WB-1:0] e_cost;
  assign {e_vis, e_dist, e_pred, e_cost} = vm_rdata;

  logic [DB:0]   cand;
  logic [DB-1:0] cand_sat;
  logic          take;
  logic          in_acc;

  dgsp_wmem u_wmem (
    .clk_i, .we_i(wm_we), .waddr_i(wm_waddr), .wdata_i(weight_i),
    .raddr_i(wm_raddr), .rdata_o(wm_rdata)
  );
  dgsp_vmem u_vmem (
    .clk_i, .we_i(vm_we), .waddr_i(vm_waddr), .wdata_i(vm_wdata),
    .raddr_i(vm_raddr), .rdata_o(vm_rdata)
  );

  // active vertex count, zero counts as one, saturates at 16
  always_comb begin
    n_c = vcnt_q;
    if (vcnt_q == 5'd0) n_c = 5'd1;
    if (vcnt_q > 5'(NV)) n_c = 5'(NV);
  end

  // input waits while a query runs or while a result is held by the receiver
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;

  // relax candidate, saturating at infinity
  assign cand = {1'b0, seld_q} + {5'd0, wm_rdata};
  assign cand_sat = (cand >= {1'b0, DistInf}) ? DistInf : cand[DB-1:0];

  // entry on the read port is an unvisited candidate; ties go to the later index
  assign take = !e_vis && (e_dist <= best_q);

  assign out_valid_o      = out_valid_q;
  assign vertex_o         = res_q.vertex;
  assign edge_cost_o      = res_q.edge_cost;
  assign total_distance_o = res_q.total_distance;
  assign reachable_o      = res_q.reachable;
  assign last_o           = res_q.last;

  always_comb begin
    state_d = state_q;
    org_d = org_q; dst_d = dst_q; idx_d = idx_q; sel_d = sel_q;
    seld_d = seld_q; best_d = best_q; found_d = found_q; step_d = step_q;
    tot_d = tot_q; cur_d = cur_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d = res_q;
    wm_we = 1'b0;
    wm_waddr = {row_i, col_i};
    wm_raddr = {org_q, idx_q};
    vm_we = 1'b0;
    vm_waddr = idx_q;
    vm_wdata = vm_rdata;
    vm_raddr = idx_q;
    unique case (state_q)
      // accepting an item implies the result register is free this cycle
      ST_IDLE: begin
        if (in_acc) begin
          if (func_e'(func_i) == FUNC_LOAD) begin
            wm_we = 1'b1;
          end else begin
            org_d = origin_i;
            dst_d = destination_i;
            if ({1'b0, origin_i} >= n_c || {1'b0, destination_i} >= n_c) begin
              res_d = '{vertex: destination_i, edge_cost: '0,
                        total_distance: DistInf, reachable: 1'b0, last: 1'b1};
              out_valid_d = 1'b1;
            end else if (origin_i == destination_i) begin
              res_d = '{vertex: origin_i, edge_cost: '0,
                        total_distance: '0, reachable: 1'b1, last: 1'b1};
              out_valid_d = 1'b1;
            end else begin
              idx_d = '0;
              state_d = ST_INIT_RD;
            end
          end
        end
      end
      // weight origin->idx is read on the default matrix address
      ST_INIT_RD: begin
        state_d = ST_INIT_WR;
      end
      // seed entry idx from the origin row, origin marked visited
      ST_INIT_WR: begin
        vm_we = 1'b1;
        vm_wdata = {(idx_q == org_q),
                    (wm_rdata == WeightInf) ? DistInf : {4'd0, wm_rdata},
                    org_q, wm_rdata};
        if ({1'b0, idx_q} == n_c - 5'd1) begin
          state_d = ST_SEL_RD;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ST_INIT_RD;
        end
      end
      // start a selection scan at entry 0
      ST_SEL_RD: begin
        vm_raddr = '0;
        idx_d = '0;
        best_d = DistInf;
        found_d = 1'b0;
        state_d = ST_SEL;
      end
      // read port holds entry idx; next address issued each cycle
      ST_SEL: begin
        if (take) begin
          best_d = e_dist; sel_d = idx_q; found_d = 1'b1;
        end
        if ({1'b0, idx_q} == n_c - 5'd1) begin
          if (found_q || take) begin
            // fetch the chosen entry again so it can be marked visited
            vm_raddr = sel_d;
            seld_d = best_d;
            state_d = ST_MARK;
          end else begin
            // no unvisited vertex left
            state_d = ST_WALK_RD;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          vm_raddr = idx_q + 1'b1;
        end
      end
      // mark selected vertex visited; an infinite pick relaxes nothing
      ST_MARK: begin
        vm_we = 1'b1;
        vm_waddr = sel_q;
        vm_wdata = {1'b1, e_dist, e_pred, e_cost};
        idx_d = '0;
        if (seld_q == DistInf) state_d = ST_SEL_RD;
        else                   state_d = ST_RELAX_RD;
      end
      // read entry idx and weight sel->idx
      ST_RELAX_RD: begin
        wm_raddr = {sel_q, idx_q};
        state_d = ST_RELAX_WR;
      end
      // update entry idx when the path through sel is shorter
      ST_RELAX_WR: begin
        if (!e_vis && wm_rdata != WeightInf && e_dist > cand_sat) begin
          vm_we = 1'b1;
          vm_wdata = {1'b0, cand_sat, sel_q, wm_rdata};
        end
        if ({1'b0, idx_q} == n_c - 5'd1) begin
          state_d = ST_SEL_RD;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ST_RELAX_RD;
        end
      end
      // fetch destination entry
      ST_WALK_RD: begin
        vm_raddr = dst_q;
        cur_d = dst_q;
        step_d = '0;
        state_d = ST_WALK_DST;
      end
      // destination entry gives total distance, infinity means unreachable
      ST_WALK_DST: begin
        tot_d = e_dist;
        vm_raddr = cur_q;
        if (e_dist == DistInf) begin
          if (!out_valid_q || !out_stall_i) begin
            res_d = '{vertex: dst_q, edge_cost: '0,
                      total_distance: DistInf, reachable: 1'b0, last: 1'b1};
            out_valid_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_WALK_OUT;
        end
      end
      // read port holds entry cur; one path item per free output slot
      ST_WALK_OUT: begin
        vm_raddr = cur_q;
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (cur_q == org_q || step_q + 5'd1 >= n_c) begin
            res_d = '{vertex: org_q, edge_cost: '0,
                      total_distance: tot_q, reachable: 1'b1, last: 1'b1};
            state_d = ST_IDLE;
          end else begin
            res_d = '{vertex: cur_q, edge_cost: e_cost,
                      total_distance: tot_q, reachable: 1'b1, last: 1'b0};
            step_d = step_q + 5'd1;
            // a predecessor beyond the vertex count falls back to the origin
            cur_d = ({1'b0, e_pred} >= n_c) ? org_q : e_pred;
            vm_raddr = cur_d;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vcnt_q <= 5'd16;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) vcnt_q <= cfg_data_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    org_q <= org_d; dst_q <= dst_d; idx_q <= idx_d; sel_q <= sel_d;
    seld_q <= seld_d; best_q <= best_d; found_q <= found_d; step_q <= step_d;
    tot_q <= tot_d; cur_q <= cur_d; res_q <= res_d;
  end
endmodule

// ===== design/dgsp_checker.sv =====
// port level checks for dense_graph_shortest_path, bound to the top level
// depends on nothing but the top level ports
module dgsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        reachable_o,
  input logic        last_o,
  input logic [19:0] total_distance_o
);
  // an unreachable item is always the last one
  a_unreach_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o |-> last_o) else $error("unreachable not last");
  // unreachable reports infinite distance
  a_unreach_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o |-> total_distance_o == 20'hfffff)
    else $error("bad distance");
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_distance_o))
    else $error("result dropped");
  // no item is taken while a result waits on the receiver
  a_wait_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item taken while result waits");
endmodule

bind dense_graph_shortest_path dgsp_checker u_dgsp_checker (.*);
